/* src/spa_pkg.sv */
// Shared types, field widths and codes for the sparse polynomial adder.
package spa_pkg;

    // Field widths of the request and result items.
    localparam int CMD_W  = 2;
    localparam int EXPO_W = 16;
    localparam int COEF_W = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;

    // Packed stream widths.
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = CMD_W + 1;
    localparam int M_TDATA_W = EXPO_W + COEF_W;
    localparam int M_TUSER_W = STAT_W + 1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_NEW      = 3'd0;
    localparam logic [STAT_W-1:0] ST_COMBINED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_SUM      = 3'd5;

    // Saturation limits of a coefficient.
    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // One stored polynomial term.
    typedef struct packed {
        logic [EXPO_W-1:0]        expo;
        logic signed [COEF_W-1:0] coef;
    } term_t;

    // Result of the shared compare and add unit.
    typedef struct packed {
        logic                     lt;
        logic                     eq;
        logic signed [COEF_W-1:0] sum;
    } alu_res_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SEARCH,
        S_INS_SHIFT,
        S_DEL_CHECK,
        S_DEL_SHIFT,
        S_ADD_CHECK,
        S_ADD_MERGE
    } state_t;

endpackage

/* src/spa_term_alu.sv */
// Shared term unit: exponent compare and saturating coefficient add.
module spa_term_alu (
    input  spa_pkg::term_t    x_term,
    input  spa_pkg::term_t    y_term,
    output spa_pkg::alu_res_t res
);
    import spa_pkg::*;

    logic [COEF_W:0] wide_sum;
    logic            ovf;

    // One extra bit catches overflow of the signed add.
    assign wide_sum = {x_term.coef[COEF_W-1], x_term.coef}
                    + {y_term.coef[COEF_W-1], y_term.coef};
    assign ovf      = wide_sum[COEF_W] ^ wide_sum[COEF_W-1];

    always_comb begin
        res.lt = x_term.expo < y_term.expo;
        res.eq = x_term.expo == y_term.expo;
        if (ovf) begin
            res.sum = wide_sum[COEF_W] ? COEF_MIN : COEF_MAX;
        end else begin
            res.sum = wide_sum[COEF_W-1:0];
        end
    end

endmodule

/* src/sparse_polynomial_adder_core.sv */
// Top level of the sparse polynomial adder: sequencer, term memory and result register.
//
// The block keeps two sparse polynomials, each a sorted table of up to MAX_TERMS
// terms. Requests arrive on the s_ stream: tuser carries the command and the
// polynomial select, tdata the exponent, coefficient and delete position.
// Results leave on the m_ stream: tuser carries status and sum_valid, tdata the
// sum term, and tlast marks the final result of each request.
// An insert or a delete gives one result; an add gives one result per sum term
// (or a single empty-sum result). An unused command gives no result.
// One request is worked at a time; s_tready is high only while the block idles.
// All table accesses go through one memory with a single write port and two
// registered read ports, and one shared compare and add unit, one term per cycle.
// Results go through an output register, so a new request is taken while the
// last result still waits; a stalled receiver holds the sequencer at the step
// that emits the next result. Reset empties both polynomials at once; table
// contents are not cleared since only entries below the term count are read.
module sparse_polynomial_adder_core #(
    parameter int MAX_TERMS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // exponent[15:0], coefficient[47:16], position[52:48], zero pad
    input  logic [spa_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[1:0], poly_sel[2]
    input  logic [spa_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_exponent[15:0], out_coefficient[47:16]
    output logic [spa_pkg::M_TDATA_W-1:0] m_tdata,
    // status[2:0], sum_valid[3]
    output logic [spa_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import spa_pkg::*;

    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

    // Request fields.
    logic                     in_accept;
    logic [CMD_W-1:0]         in_cmd;
    logic                     in_sel;
    logic [EXPO_W-1:0]        in_expo;
    logic signed [COEF_W-1:0] in_coef;
    logic [POS_W-1:0]         in_pos;

    // Sequencer and indexes.
    state_t                   state_reg, state_next;
    logic                     sel_reg, sel_next;
    logic [EXPO_W-1:0]        expo_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         a_idx_reg, a_idx_next;
    logic [CNT_W-1:0]         b_idx_reg, b_idx_next;
    logic [CNT_W-1:0]         ins_pos_reg, ins_pos_next;
    logic [CNT_W-1:0]         count_reg [2];
    logic [CNT_W-1:0]         count_next [2];

    // Term memory.
    term_t                    term_mem [MEM_DEPTH];
    term_t                    rd_a_reg, rd_b_reg;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_widx;
    term_t                    mem_wdata;
    logic [IDX_W-1:0]         rd_idx_a, rd_idx_b;

    // Shared unit.
    term_t                    alu_y;
    alu_res_t                 alu_res;

    // Conditions.
    logic                     out_free;
    logic [CNT_W-1:0]         cur_cnt;
    logic                     a_has, b_has;
    logic                     srch_lt, srch_eq, is_full;
    logic                     pos_bad, shift_more, del_more, sum_empty;
    logic                     take_a, take_b;
    logic [CNT_W-1:0]         a_idx_adv, b_idx_adv;
    logic                     merge_last;

    // Result register.
    logic                     emit;
    logic [STAT_W-1:0]        emit_status;
    logic                     emit_sum_valid;
    logic [EXPO_W-1:0]        emit_expo;
    logic signed [COEF_W-1:0] emit_coef;
    logic                     emit_last;
    logic                     m_tvalid_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic                     out_sum_valid_reg;
    logic [EXPO_W-1:0]        out_expo_reg;
    logic signed [COEF_W-1:0] out_coef_reg;
    logic                     out_last_reg;

    // Unpack the request.
    assign in_accept = s_tvalid && s_tready;
    assign in_cmd    = s_tuser[CMD_W-1:0];
    assign in_sel    = s_tuser[CMD_W];
    assign in_expo   = s_tdata[EXPO_W-1:0];
    assign in_coef   = s_tdata[EXPO_W+COEF_W-1:EXPO_W];
    assign in_pos    = s_tdata[EXPO_W+COEF_W+POS_W-1:EXPO_W+COEF_W];
    assign s_tready  = (state_reg == S_IDLE);

    // The shared unit compares the read term with the request term or, while
    // merging, with the term read from the second polynomial.
    assign alu_y = (state_reg == S_ADD_MERGE) ? rd_b_reg : term_t'{expo: expo_reg,
                                                                  coef: coef_reg};

    spa_term_alu u_alu (
        .x_term (rd_a_reg),
        .y_term (alu_y),
        .res    (alu_res)
    );

    // Step conditions. During an add sel_reg is zero, so cur_cnt is the first count.
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cur_cnt    = count_reg[sel_reg];
    assign a_has      = a_idx_reg < cur_cnt;
    assign b_has      = b_idx_reg < count_reg[1];
    assign srch_lt    = a_has && alu_res.lt;
    assign srch_eq    = a_has && alu_res.eq;
    assign is_full    = (cur_cnt == MAX_CNT);
    assign pos_bad    = (pos_reg == '0) || (CMP_W'(pos_reg) > CMP_W'(cur_cnt));
    assign shift_more = a_idx_reg > ins_pos_reg;
    assign del_more   = (a_idx_reg + ONE_CNT) < cur_cnt;
    assign sum_empty  = (count_reg[0] == '0) && (count_reg[1] == '0);
    assign take_a     = !b_has || (a_has && alu_res.lt);
    assign take_b     = !take_a && (!a_has || !alu_res.eq);
    assign a_idx_adv  = a_idx_reg + CNT_W'(!take_b);
    assign b_idx_adv  = b_idx_reg + CNT_W'(!take_a);
    assign merge_last = (a_idx_adv >= cur_cnt) && (b_idx_adv >= count_reg[1]);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    case (in_cmd)
                        CMD_INSERT: state_next = S_INS_SEARCH;
                        CMD_DELETE: state_next = S_DEL_CHECK;
                        CMD_ADD:    state_next = S_ADD_CHECK;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_SEARCH: begin
                if (!srch_lt && out_free) begin
                    state_next = (srch_eq || is_full) ? S_IDLE : S_INS_SHIFT;
                end
            end
            S_INS_SHIFT: begin
                if (!shift_more && out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DEL_CHECK: begin
                if (!pos_bad) begin
                    state_next = S_DEL_SHIFT;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DEL_SHIFT: begin
                if (!del_more && out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_ADD_CHECK: begin
                if (!sum_empty) begin
                    state_next = S_ADD_MERGE;
                end else if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_ADD_MERGE: begin
                if (out_free && merge_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath control: indexes, memory accesses, counts and results.
    always_comb begin
        sel_next       = sel_reg;
        a_idx_next     = a_idx_reg;
        b_idx_next     = b_idx_reg;
        ins_pos_next   = ins_pos_reg;
        count_next     = count_reg;
        rd_idx_a       = a_idx_reg[IDX_W-1:0];
        rd_idx_b       = b_idx_reg[IDX_W-1:0];
        mem_we         = 1'b0;
        mem_widx       = a_idx_reg[IDX_W-1:0];
        mem_wdata      = rd_a_reg;
        emit           = 1'b0;
        emit_status    = ST_SUM;
        emit_sum_valid = 1'b0;
        emit_expo      = '0;
        emit_coef      = '0;
        emit_last      = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    sel_next   = (in_cmd == CMD_ADD) ? 1'b0 : in_sel;
                    a_idx_next = '0;
                    b_idx_next = '0;
                    rd_idx_a   = '0;
                    rd_idx_b   = '0;
                end
            end
            S_INS_SEARCH: begin
                if (srch_lt) begin
                    a_idx_next = a_idx_reg + ONE_CNT;
                    rd_idx_a   = a_idx_next[IDX_W-1:0];
                end else if (out_free) begin
                    if (srch_eq) begin
                        mem_we      = 1'b1;
                        mem_wdata   = term_t'{expo: rd_a_reg.expo, coef: alu_res.sum};
                        emit        = 1'b1;
                        emit_status = ST_COMBINED;
                    end else if (is_full) begin
                        emit        = 1'b1;
                        emit_status = ST_FULL;
                    end else begin
                        // Shift down from the top, reading one entry ahead.
                        ins_pos_next = a_idx_reg;
                        a_idx_next   = cur_cnt;
                        rd_idx_a     = IDX_W'(cur_cnt - ONE_CNT);
                    end
                end
            end
            S_INS_SHIFT: begin
                if (shift_more) begin
                    mem_we     = 1'b1;
                    a_idx_next = a_idx_reg - ONE_CNT;
                    rd_idx_a   = IDX_W'(a_idx_reg - TWO_CNT);
                end else if (out_free) begin
                    mem_we              = 1'b1;
                    mem_wdata           = term_t'{expo: expo_reg, coef: coef_reg};
                    count_next[sel_reg] = cur_cnt + ONE_CNT;
                    emit                = 1'b1;
                    emit_status         = ST_NEW;
                end
            end
            S_DEL_CHECK: begin
                if (!pos_bad) begin
                    a_idx_next = CNT_W'(CMP_W'(pos_reg) - CMP_W'(1));
                    rd_idx_a   = IDX_W'(pos_reg);
                end else if (out_free) begin
                    emit        = 1'b1;
                    emit_status = ST_BADPOS;
                end
            end
            S_DEL_SHIFT: begin
                if (del_more) begin
                    mem_we     = 1'b1;
                    a_idx_next = a_idx_reg + ONE_CNT;
                    rd_idx_a   = IDX_W'(a_idx_reg + TWO_CNT);
                end else if (out_free) begin
                    count_next[sel_reg] = cur_cnt - ONE_CNT;
                    emit                = 1'b1;
                    emit_status         = ST_DELETED;
                end
            end
            S_ADD_CHECK: begin
                if (sum_empty && out_free) begin
                    emit = 1'b1;
                end
            end
            S_ADD_MERGE: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_sum_valid = 1'b1;
                    emit_expo      = take_b ? rd_b_reg.expo : rd_a_reg.expo;
                    if (take_a) begin
                        emit_coef = rd_a_reg.coef;
                    end else if (take_b) begin
                        emit_coef = rd_b_reg.coef;
                    end else begin
                        emit_coef = alu_res.sum;
                    end
                    emit_last  = merge_last;
                    a_idx_next = a_idx_adv;
                    b_idx_next = b_idx_adv;
                    rd_idx_a   = a_idx_adv[IDX_W-1:0];
                    rd_idx_b   = b_idx_adv[IDX_W-1:0];
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sel_reg      <= 1'b0;
            a_idx_reg    <= '0;
            b_idx_reg    <= '0;
            ins_pos_reg  <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sel_reg      <= sel_next;
            a_idx_reg    <= a_idx_next;
            b_idx_reg    <= b_idx_next;
            ins_pos_reg  <= ins_pos_next;
            count_reg    <= count_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request payload and result payload.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            expo_reg <= in_expo;
            coef_reg <= in_coef;
            pos_reg  <= in_pos;
        end
        if (emit) begin
            out_status_reg    <= emit_status;
            out_sum_valid_reg <= emit_sum_valid;
            out_expo_reg      <= emit_expo;
            out_coef_reg      <= emit_coef;
            out_last_reg      <= emit_last;
        end
    end

    // Term memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            term_mem[{sel_reg, mem_widx}] <= mem_wdata;
        end
        rd_a_reg <= term_mem[{sel_next, rd_idx_a}];
        rd_b_reg <= term_mem[{1'b1, rd_idx_b}];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_coef_reg, out_expo_reg};
    assign m_tuser  = {out_sum_valid_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // Neither table ever holds more terms than it has room for.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg[0] <= MAX_CNT) && (count_reg[1] <= MAX_CNT))
        else $error("term count above table size");

    // The table is written only by insert and delete steps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_INS_SEARCH || state_reg == S_INS_SHIFT ||
                    state_reg == S_DEL_SHIFT))
        else $error("term memory written outside insert or delete");

    // A term count changes only together with the result that reports it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((count_next[0] != count_reg[0]) || (count_next[1] != count_reg[1])) |-> emit)
        else $error("term count changed without a result");

    // While merging, at least one side still has terms and no index runs past its count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADD_MERGE) |->
            (a_idx_reg <= count_reg[0]) && (b_idx_reg <= count_reg[1]) &&
            ((a_idx_reg < count_reg[0]) || (b_idx_reg < count_reg[1])))
        else $error("merge index out of range");

    // The insert shift stays between the insert place and the table top.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_SHIFT) |->
            (a_idx_reg >= ins_pos_reg) && (a_idx_reg < MAX_CNT))
        else $error("insert shift index out of range");
`endif

endmodule
